### rtl/core/bspc_pkg.sv
package bspc_pkg;

  localparam int WORDS     = 64;
  localparam int WORD_BITS = 32;
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int INDEX_W   = 16;
  localparam int WIDX_W    = INDEX_W - BIT_AW;
  localparam int LIST_W    = 11;
  localparam int COUNT_W   = 12;
  localparam int CAPACITY  = WORDS * WORD_BITS;

  localparam logic [WIDX_W:0] WORDS_L = (WIDX_W + 1)'(WORDS);

  typedef enum logic [1:0] {
    MODE_SET   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_TEST  = 2'd2,
    MODE_LIST  = 2'd3
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // capture the word and start the store read
    logic finish;    // produce the single result, write back set or clear
    logic load_rem;  // load the word to be listed
    logic emit;      // report the lowest remaining set bit
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free; // output register can take a result this cycle
    logic multi;     // listing a non-empty word inside the store
    logic rem_last;  // the lowest remaining bit is the final one
  } status_t;

endpackage

### rtl/core/bspc_if.sv
interface bspc_in_if import bspc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [INDEX_W-1:0] bit_addr;

  modport source (output valid, output mode, output bit_addr, input ready);
  modport sink   (input valid, input mode, input bit_addr, output ready);
endinterface

interface bspc_out_if import bspc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [LIST_W-1:0]  listed_index;
  logic [COUNT_W-1:0] set_count;
  logic               out_of_range;
  logic               last;

  modport source (output valid, output found, output listed_index, output set_count,
                  output out_of_range, output last, input ready);
  modport sink   (input valid, input found, input listed_index, input set_count,
                  input out_of_range, input last, output ready);
endinterface

### rtl/core/bspc_ctrl.sv
module bspc_ctrl import bspc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_accept_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    in_ready_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        if (status_i.multi) begin
          cmd_o.load_rem = 1'b1;
          state_d        = ST_EMIT;
        end else if (status_i.slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.rem_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule

### rtl/core/bspc_dp.sv
module bspc_dp import bspc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [1:0]         in_mode_i,
  input  logic [INDEX_W-1:0] in_bit_addr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_found_o,
  output logic [LIST_W-1:0]  out_listed_index_o,
  output logic [COUNT_W-1:0] out_set_count_o,
  output logic               out_out_of_range_o,
  output logic               out_last_o
);

  logic [WORD_BITS-1:0] mem_q [WORDS];
  logic [WORDS-1:0]     vld_q;

  mode_e                mode_q;
  logic [INDEX_W-1:0]   idx_q;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rdv_q;
  logic [WORD_BITS-1:0] rem_q;
  logic [COUNT_W-1:0]   count_q, count_d;

  logic                 ov_q;
  logic                 of_q, oor_q, olast_q;
  logic [LIST_W-1:0]    oidx_q;
  logic [COUNT_W-1:0]   ocnt_q;

  logic [WORD_AW-1:0]   in_addr;
  logic [WIDX_W-1:0]    word_idx;
  logic [WORD_AW-1:0]   addr;
  logic [BIT_AW-1:0]    bit_sel;
  logic                 in_store;
  logic [WORD_BITS-1:0] cur, mask, low, rem_nxt;
  logic                 bit_val;
  logic [BIT_AW-1:0]    pos;
  logic [INDEX_W-1:0]   full_idx;
  logic                 we;
  logic [WORD_BITS-1:0] wdata;
  logic                 load;
  logic                 r_found, r_oor, r_last;
  logic [LIST_W-1:0]    r_idx;

  assign in_addr  = in_bit_addr_i[BIT_AW +: WORD_AW];
  assign word_idx = idx_q[INDEX_W-1:BIT_AW];
  assign addr     = idx_q[BIT_AW +: WORD_AW];
  assign bit_sel  = idx_q[BIT_AW-1:0];
  assign in_store = ({1'b0, word_idx} < WORDS_L);
  // A word never written since reset reads as zero.
  assign cur      = rdv_q ? rd_q : '0;
  assign mask     = WORD_BITS'(1) << bit_sel;
  assign bit_val  = |(cur & mask);

  // Lowest set bit of the remaining word, as a one-hot and as a position.
  assign low     = rem_q & (~rem_q + WORD_BITS'(1));
  assign rem_nxt = rem_q & ~low;
  always_comb begin
    pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low[j]) begin
        pos = pos | BIT_AW'(j);
      end
    end
  end
  assign full_idx = {word_idx, pos};

  always_comb begin
    we      = 1'b0;
    wdata   = cur;
    count_d = count_q;
    r_found = 1'b0;
    r_oor   = 1'b0;
    r_last  = 1'b1;
    r_idx   = '0;
    if (cmd_i.finish) begin
      case (mode_q)
        MODE_SET: begin
          r_oor = !in_store;
          if (in_store && !bit_val) begin
            we      = 1'b1;
            wdata   = cur | mask;
            count_d = count_q + COUNT_W'(1);
          end
        end
        MODE_CLEAR: begin
          if (in_store && bit_val) begin
            we      = 1'b1;
            wdata   = cur & ~mask;
            count_d = count_q - COUNT_W'(1);
          end
        end
        MODE_TEST: r_found = in_store && bit_val;
        default:   r_oor   = !in_store;
      endcase
    end else if (cmd_i.emit) begin
      r_found = 1'b1;
      r_idx   = full_idx[LIST_W-1:0];
      r_last  = (rem_nxt == '0);
    end
  end

  assign load = cmd_i.finish | cmd_i.emit;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr] <= wdata;
    end
    if (cmd_i.accept) begin
      rd_q <= mem_q[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (we) begin
        vld_q[addr] <= 1'b1;
      end
      count_q <= count_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_e'(in_mode_i);
      idx_q  <= in_bit_addr_i;
      rdv_q  <= vld_q[in_addr];
    end
    if (cmd_i.load_rem) begin
      rem_q <= cur;
    end else if (cmd_i.emit) begin
      rem_q <= rem_nxt;
    end
    if (load) begin
      of_q    <= r_found;
      oidx_q  <= r_idx;
      ocnt_q  <= count_d;
      oor_q   <= r_oor;
      olast_q <= r_last;
    end
  end

  assign status_o.slot_free = !ov_q || out_ready_i;
  assign status_o.multi     = (mode_q == MODE_LIST) && in_store && (cur != '0);
  assign status_o.rem_last  = (rem_nxt == '0);

  assign out_valid_o        = ov_q;
  assign out_found_o        = of_q;
  assign out_listed_index_o = oidx_q;
  assign out_set_count_o    = ocnt_q;
  assign out_out_of_range_o = oor_q;
  assign out_last_o         = olast_q;

endmodule

### rtl/core/bitset_store_with_popcount.sv
// Bitmap of 64 words of 32 bits with a running count of set bits. Each input
// word sets, clears or tests one bit, or lists the set bits of the word that
// holds the index, lowest first, with last marking the final result. Set,
// clear and test do a store read, then result and write-back; a list does a
// store read, then emits each set bit, paced by the output register.
// A new input word is taken once the previous one has placed its final
// result in the output register. The store reads as zero from reset through
// per-word valid flags, so no clearing pass is needed. Setting a bit beyond
// the store, or listing such a word, flags out_of_range and changes nothing.
module bitset_store_with_popcount import bspc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  bspc_in_if.sink         in_i,
  bspc_out_if.source      out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    in_accept;

  assign in_i.ready = in_ready;
  assign in_accept  = in_i.valid && in_ready;

  bspc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready)
  );

  bspc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .in_mode_i          (in_i.mode),
    .in_bit_addr_i      (in_i.bit_addr),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_found_o        (out_o.found),
    .out_listed_index_o (out_o.listed_index),
    .out_set_count_o    (out_o.set_count),
    .out_out_of_range_o (out_o.out_of_range),
    .out_last_o         (out_o.last)
  );

  a_cmd_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.finish, cmd.load_rem, cmd.emit}))
    else $error("controller issued more than one command");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready)
    else $error("input taken again before the word was processed");

  a_result_has_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.finish || cmd.emit) |-> status.slot_free)
    else $error("result loaded while the output register was occupied");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (32'(out_o.set_count) <= 32'(CAPACITY)))
    else $error("set count exceeds the store capacity");

endmodule
